### rtl/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
// No dependencies; every other file but lir_fifo refers to this package by scoped names.
package lir_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned STEP_BITS   = 24;
  localparam int unsigned POS_BITS    = STEP_BITS + 1;
  localparam int unsigned SUM_BITS    = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int unsigned ADDR_BITS   = 3;
  localparam int unsigned DATA_BITS   = 32;

  localparam logic [POS_BITS-1:0]  ONE_POS    = POS_BITS'(1) << FRAC_BITS;
  localparam logic [STEP_BITS-1:0] MIN_STEP   = STEP_BITS'(1) << (FRAC_BITS - 5);
  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1) << FRAC_BITS;
  localparam logic signed [SUM_BITS-1:0] HALF_LSB = SUM_BITS'(1) << (FRAC_BITS - 1);

  // register index, taken from paddr[ADDR_BITS-1:2]
  localparam logic [ADDR_BITS-3:0] REG_STEP_RATIO = '0;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_SINGLE = 2'd1,
    CMD_SPAN   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          run_end;
    logic                          signal_end;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e                     kind;
    logic signed [SAMPLE_BITS-1:0] prev;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [SAMPLE_BITS-1:0] cur;
    logic                          last;
  } cmd_t;

endpackage

### rtl/lir_fifo.sv
// Small register queue, parameterised in width and depth.
// Depends on nothing; used for the command queue and the result queue.
module lir_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/lir_front.sv
// Front end: accepts input items, tracks the held sample and classifies
// each item into a command for the back end. Depends on lir_pkg.
module lir_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lir_pkg::in_item_t in_item_i,
  input  logic              cmd_full_i,
  output logic              cmd_push_o,
  output lir_pkg::cmd_t     cmd_o
);

  logic signed [lir_pkg::SAMPLE_BITS-1:0] prev_q, prev_d;
  logic                                   have_prev_q, have_prev_d;
  logic                                   accept;

  assign accept     = push_i && !cmd_full_i;
  assign cmd_push_o = accept;

  always_comb begin
    cmd_o.prev = prev_q;
    cmd_o.cur  = in_item_i.in_sample;
    cmd_o.last = in_item_i.last_sample;
    cmd_o.diff = {in_item_i.in_sample[lir_pkg::SAMPLE_BITS-1], in_item_i.in_sample}
               - {prev_q[lir_pkg::SAMPLE_BITS-1], prev_q};
    if (have_prev_q) begin
      cmd_o.kind = lir_pkg::CMD_SPAN;
    end else if (in_item_i.last_sample) begin
      cmd_o.kind = lir_pkg::CMD_SINGLE;
    end else begin
      cmd_o.kind = lir_pkg::CMD_HOLD;
    end

    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    if (accept) begin
      prev_d      = in_item_i.in_sample;
      have_prev_d = !in_item_i.last_sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
    end
  end

endmodule

### rtl/lir_back.sv
// Back end: walks output positions across one span, one result per cycle while
// the result queue has room, interpolating with a single multiplier. Depends on lir_pkg.
module lir_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [lir_pkg::STEP_BITS-1:0]   step_ratio_i,
  input  logic                            cmd_empty_i,
  input  lir_pkg::cmd_t                   cmd_i,
  output logic                            cmd_pop_o,
  input  logic                            res_full_i,
  output logic                            res_push_o,
  output lir_pkg::out_item_t              res_o
);

  typedef enum logic {
    B_IDLE,
    B_SPAN
  } back_state_e;

  localparam int unsigned S = lir_pkg::SAMPLE_BITS;
  localparam int unsigned F = lir_pkg::FRAC_BITS;
  localparam int unsigned P = lir_pkg::POS_BITS;
  localparam int unsigned W = lir_pkg::SUM_BITS;

  back_state_e              state_q, state_d;
  logic [P-1:0]             pos_q, pos_d;
  logic signed [S-1:0]      prev_q, prev_d, cur_q, cur_d;
  logic signed [S:0]        diff_q, diff_d;
  logic                     last_q, last_d;

  logic [lir_pkg::STEP_BITS-1:0]       step_eff;
  logic [P-1:0]                        pos_nxt, pos_after;
  logic                                in_span, run_done, lands;
  logic signed [lir_pkg::SUM_BITS-1:0] prod, base, sum;

  assign step_eff  = (step_ratio_i < lir_pkg::MIN_STEP) ? lir_pkg::MIN_STEP : step_ratio_i;
  assign pos_nxt   = pos_q + P'(step_eff);
  assign pos_after = pos_q - lir_pkg::ONE_POS;
  assign in_span   = (pos_q[P-1:F] == '0);
  assign run_done  = (pos_nxt[P-1:F] != '0);
  assign lands     = last_q && (pos_nxt == lir_pkg::ONE_POS);

  assign prod = W'(diff_q) * W'($signed({1'b0, pos_q[F-1:0]}));
  assign base = $signed({{2{prev_q[S-1]}}, prev_q, {F{1'b0}}});
  assign sum  = base + prod + lir_pkg::HALF_LSB;

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    prev_d     = prev_q;
    cur_d      = cur_q;
    diff_d     = diff_q;
    last_d     = last_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{out_sample: cur_q, run_end: 1'b1, signal_end: 1'b1};

    unique case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            lir_pkg::CMD_SPAN: begin
              prev_d  = cmd_i.prev;
              cur_d   = cmd_i.cur;
              diff_d  = cmd_i.diff;
              last_d  = cmd_i.last;
              state_d = B_SPAN;
            end
            lir_pkg::CMD_SINGLE: begin
              res_push_o = 1'b1;
              res_o      = '{out_sample: cmd_i.cur, run_end: 1'b1, signal_end: 1'b1};
              pos_d      = '0;
            end
            default: begin
              pos_d = '0;
            end
          endcase
        end
      end
      B_SPAN: begin
        if (!res_full_i) begin
          if (in_span) begin
            res_push_o       = 1'b1;
            res_o.out_sample = sum[F +: S];
            res_o.run_end    = run_done && !lands;
            res_o.signal_end = run_done && !lands && last_q;
            pos_d            = pos_nxt;
          end else begin
            res_push_o = last_q && (pos_after == '0);
            pos_d      = last_q ? '0 : pos_after;
            state_d    = B_IDLE;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    cur_q  <= cur_d;
    diff_q <= diff_d;
    last_q <= last_d;
  end

endmodule

### rtl/linear_interp_resampler_core.sv
// Top level of the linear interpolation resampler: step register, front end,
// command queue, back end and result queue. Depends on lir_pkg, lir_fifo,
// lir_front and lir_back.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------
//  input     | push / full        | in_data_i  (in_sample, last_sample)
//  result    | pop / empty        | out_data_o (out_sample, run_end, signal_end)
//  config    | APB, pready tied 1 | step_ratio at byte address 0
//
// The back end dispatches a span item, emits its results from the position loop
// through its single multiplier and then closes the span; a held first sample or
// a one-sample signal needs only the dispatch.
// Reset clears the step register to 1.0, the held sample and both queues.
// Either side may stall freely: the queues decouple front, back and output.
module linear_interp_resampler_core #(
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  lir_pkg::in_item_t               in_data_i,
  output logic                            empty,
  input  logic                            pop,
  output lir_pkg::out_item_t              out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lir_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [lir_pkg::DATA_BITS-1:0]   pwdata,
  output logic [lir_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready
);

  logic [lir_pkg::STEP_BITS-1:0] step_q;
  logic                          step_sel;

  lir_pkg::cmd_t      cmd_in, cmd_out;
  lir_pkg::out_item_t res_in;
  logic               cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic               res_push, res_full;

  assign pready   = 1'b1;
  assign step_sel = (paddr[lir_pkg::ADDR_BITS-1:2] == lir_pkg::REG_STEP_RATIO);
  assign prdata   = step_sel ? lir_pkg::DATA_BITS'(step_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= lir_pkg::STEP_RESET;
    end else if (psel && penable && pwrite && pready && step_sel) begin
      step_q <= pwdata[lir_pkg::STEP_BITS-1:0];
    end
  end

  assign full = cmd_full;

  lir_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_item_i  (in_data_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  lir_fifo #(
    .WIDTH ($bits(lir_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  lir_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_ratio_i (step_q),
    .cmd_empty_i  (cmd_empty),
    .cmd_i        (cmd_out),
    .cmd_pop_o    (cmd_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  lir_fifo #(
    .WIDTH ($bits(lir_pkg::out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

endmodule

### rtl/lir_checker.sv
// Port-level checks for the resampler core, bound to the top level.
// Depends on lir_pkg and linear_interp_resampler_core.
module lir_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            push,
  input logic                            full,
  input lir_pkg::in_item_t               in_data_i,
  input logic                            empty,
  input logic                            pop,
  input lir_pkg::out_item_t              out_data_o,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [lir_pkg::ADDR_BITS-1:0]   paddr,
  input logic [lir_pkg::DATA_BITS-1:0]   pwdata,
  input logic [lir_pkg::DATA_BITS-1:0]   prdata,
  input logic                            pready
);

  // end of signal always closes the run
  a_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_data_o.signal_end |-> out_data_o.run_end)
    else $error("signal_end without run_end");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_data_o))
    else $error("waiting result changed");

  a_step_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr == '0) ##1 (psel && !pwrite && paddr == '0)
    |-> prdata[lir_pkg::STEP_BITS-1:0] == $past(pwdata[lir_pkg::STEP_BITS-1:0]))
    else $error("step register readback mismatch");

  a_step_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[lir_pkg::DATA_BITS-1:lir_pkg::STEP_BITS] == '0)
    else $error("unused register bits read non-zero");

endmodule

bind linear_interp_resampler_core lir_checker u_lir_checker (.*);

### bench/lir_resample_checker.sv
// Checker for linear_interp_resampler_core: follows the step register writes,
// predicts the interpolated samples of each accepted item and compares each result.
// Depends on lir_pkg only; instantiated beside the block by the bench top.
module lir_resample_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  logic                          full,
  input  lir_pkg::in_item_t             in_data_i,
  input  logic                          empty,
  input  logic                          pop,
  input  lir_pkg::out_item_t            out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [lir_pkg::ADDR_BITS-1:0] paddr,
  input  logic [lir_pkg::DATA_BITS-1:0] pwdata,
  output int                            fail_count,
  output int                            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SW = lir_pkg::SAMPLE_BITS;
  localparam int unsigned FW = lir_pkg::FRAC_BITS;
  localparam int unsigned PW = lir_pkg::POS_BITS;
  localparam int unsigned TW = lir_pkg::STEP_BITS;

  logic [TW-1:0]         step_q;
  logic [TW-1:0]         next_pos;
  logic signed [SW-1:0]  held_sample;
  logic                  have_held;
  lir_pkg::out_item_t    due_results[$];
  int                    fails;

  function automatic logic signed [SW-1:0] lerp(
    input logic signed [SW-1:0] a,
    input logic signed [SW-1:0] b,
    input logic [FW:0]          frac
  );
    longint acc;
    acc = longint'(a) * (longint'(1) << FW)
        + (longint'(b) - longint'(a)) * longint'(frac)
        + (longint'(1) << (FW - 1));
    return SW'(acc >>> FW);
  endfunction

  task automatic interpolate_item(input lir_pkg::in_item_t it);
    lir_pkg::out_item_t run[$];
    lir_pkg::out_item_t res;
    logic [PW-1:0]      pos;
    logic [TW-1:0]      step;
    step = (step_q < lir_pkg::MIN_STEP) ? lir_pkg::MIN_STEP : step_q;
    if (!have_held) begin
      if (it.last_sample) begin
        res.out_sample = it.in_sample;
        res.run_end    = 1'b1;
        res.signal_end = 1'b1;
        due_results.push_back(res);
      end else begin
        held_sample = it.in_sample;
        next_pos    = '0;
        have_held   = 1'b1;
      end
      return;
    end
    pos = {1'b0, next_pos};
    while (pos < lir_pkg::ONE_POS) begin
      res            = '0;
      res.out_sample = lerp(held_sample, it.in_sample, pos[FW:0]);
      run.push_back(res);
      pos = pos + PW'(step);
    end
    pos = pos - lir_pkg::ONE_POS;
    // a position landing exactly on the final sample emits it as is
    if (it.last_sample && pos == '0) begin
      res            = '0;
      res.out_sample = it.in_sample;
      run.push_back(res);
    end
    if (run.size() > 0) begin
      res            = run.pop_back();
      res.run_end    = 1'b1;
      res.signal_end = it.last_sample;
      run.push_back(res);
    end
    foreach (run[k]) due_results.push_back(run[k]);
    if (it.last_sample) begin
      next_pos    = '0;
      held_sample = '0;
      have_held   = 1'b0;
    end else begin
      held_sample = it.in_sample;
      next_pos    = pos[TW-1:0];
    end
  endtask

  task automatic report(input string field, input longint want, input longint got);
    fails++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  task automatic check_result(input lir_pkg::out_item_t got);
    lir_pkg::out_item_t want;
    if (due_results.size() == 0) begin
      fails++;
      $error("unexpected result: out_sample %0d", got.out_sample);
      return;
    end
    want = due_results.pop_front();
    if (got.out_sample !== want.out_sample)
      report("out_sample", want.out_sample, got.out_sample);
    if (got.run_end !== want.run_end)
      report("run_end", want.run_end, got.run_end);
    if (got.signal_end !== want.signal_end)
      report("signal_end", want.signal_end, got.signal_end);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        = lir_pkg::STEP_RESET;
      next_pos      = '0;
      held_sample   = '0;
      have_held     = 1'b0;
      fails         = 0;
      due_results.delete();
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[lir_pkg::ADDR_BITS-1:2] == lir_pkg::REG_STEP_RATIO)
        step_q = pwdata[TW-1:0];
      if (push && !full) interpolate_item(in_data_i);
      if (pop && !empty) check_result(out_data_o);
      fail_count    <= fails;
      pending_count <= due_results.size();
    end
  end

endmodule

### bench/tb_linear_interp_resampler_core.sv
// Bench top for linear_interp_resampler_core: clock, reset, step writes over APB,
// directed and random sample streams with random stalls on both sides, and the verdict.
// Depends on lir_pkg, the block and lir_resample_checker.
module tb_linear_interp_resampler_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 64;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int RAND_PHASES    = 6;
  localparam int RAND_ITEMS     = 40;
  localparam int TIMEOUT_NS     = 40_000_000;

  localparam int unsigned SW = lir_pkg::SAMPLE_BITS;
  localparam int unsigned TW = lir_pkg::STEP_BITS;
  localparam int unsigned DW = lir_pkg::DATA_BITS;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          push;
  logic                          full;
  lir_pkg::in_item_t             in_data_i;
  logic                          empty;
  logic                          pop;
  lir_pkg::out_item_t            out_data_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [lir_pkg::ADDR_BITS-1:0] paddr;
  logic [DW-1:0]                 pwdata;
  logic [DW-1:0]                 prdata;
  logic                          pready;
  int                            fail_count;
  int                            pending_count;
  logic                          squeeze;
  int unsigned                   send_calm;

  linear_interp_resampler_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  lir_resample_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_data_i     (in_data_i),
    .empty         (empty),
    .pop           (pop),
    .out_data_o    (out_data_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DW-1:0] rand_step();
    logic [TW-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = TW'($urandom_range(0, 2047));
      1:       s = TW'($urandom_range(2048, 8191));
      2:       s = lir_pkg::STEP_RESET;
      3:       s = TW'($urandom_range(24'h10_0000, 24'hFF_FFFF));
      default: s = TW'($urandom_range(24'h00_2000, 24'h04_0000));
    endcase
    return {8'($urandom), s};
  endfunction

  function automatic lir_pkg::in_item_t rand_item(input int unsigned last_pct);
    lir_pkg::in_item_t it;
    case ($urandom_range(0, 9))
      0:       it.in_sample = 16'sh7FFF;
      1:       it.in_sample = 16'sh8000;
      2:       it.in_sample = SW'(int'($urandom_range(0, 32)) - 16);
      default: it.in_sample = SW'($urandom);
    endcase
    it.last_sample = ($urandom_range(0, 99) < last_pct);
    return it;
  endfunction

  task automatic send_item(input lir_pkg::in_item_t it);
    int unsigned gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 49) == 0) send_calm = 30;
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic send_sample(input logic signed [SW-1:0] s, input logic last);
    lir_pkg::in_item_t it;
    it.in_sample   = s;
    it.last_sample = last;
    send_item(it);
  endtask

  task automatic write_step(input logic [DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {lir_pkg::REG_STEP_RATIO, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // let the count take in the last accepted item, drain it, then allow the
  // back end time for held samples, which yield no result
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : drain
    int unsigned gap;
    int unsigned calm;
    logic        squeezed;
    pop      <= 1'b0;
    calm     = 0;
    squeezed = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        pop <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
        gap = 0;
      end else if (calm > 0) begin
        calm--;
        gap = 0;
      end else begin
        gap = pick_gap();
        if ($urandom_range(0, 49) == 0) calm = 40;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
    end
  end

  initial begin : stimulus
    int unsigned pct;
    rst_ni    <= 1'b0;
    push      <= 1'b0;
    in_data_i <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    squeeze   <= 1'b0;
    send_calm = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // step 1.0 out of reset: one-sample signal, full-scale swings, signal left open
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    settle();

    // zero step is clamped to the minimum; the open signal continues on the new step
    write_step('0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sd0, 1'b1);
    settle();

    // largest step: final span with no position in it
    write_step(32'h00FF_FFFF);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd6, 1'b0);
    send_sample(16'sd7, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b1);
    settle();

    // half step, upper data bits set
    write_step(32'hFF00_8000);
    send_sample(16'sd1000, 1'b0);
    send_sample(-16'sd1000, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sd1, 1'b1);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_step(p == 0 ? 32'h0000_6000 : rand_step());
      if (p == 0) squeeze <= 1'b1;
      case (p % 3)
        0:       pct = 5;
        1:       pct = 15;
        default: pct = 40;
      endcase
      repeat (RAND_ITEMS) send_item(rand_item(pct));
      settle();
    end

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
rtl/lir_pkg.sv
rtl/lir_fifo.sv
rtl/lir_front.sv
rtl/lir_back.sv
rtl/linear_interp_resampler_core.sv
rtl/lir_checker.sv
bench/lir_resample_checker.sv
bench/tb_linear_interp_resampler_core.sv
